[rtl/emsfd_pkg.sv]
// ----------------------------------------------------------------------------
// emsfd_pkg: shared types and constants of the EMS frame decoder
// Sizes, field layouts, status codes and controller states.
// ----------------------------------------------------------------------------
`default_nettype none
package emsfd_pkg;
  localparam int MaxFrame   = 32;
  localparam int NumEntries = 16;
  localparam int FrameAw    = $clog2(MaxFrame);
  localparam int LenW       = $clog2(MaxFrame + 1);
  localparam int EntAw      = $clog2(NumEntries);
  localparam int CntW       = $clog2(NumEntries + 1);
  localparam int BurnerIdx  = 2;
  localparam int HotwaterIdx = 4;

  localparam logic [1:0] StShort = 2'd0;
  localparam logic [1:0] StPoll  = 2'd1;
  localparam logic [1:0] StCrc   = 2'd2;
  localparam logic [1:0] StOk    = 2'd3;

  localparam logic OpByte  = 1'b0;
  localparam logic OpTable = 1'b1;

  localparam logic RegWatch = 1'b0;
  localparam logic RegCount = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_CRC, S_CRC_CHK, S_WALK_RD, S_WALK_B0, S_WALK_HI, S_WALK_LO,
    S_WALK_UPD, S_ACCT, S_EMIT_RD, S_EMIT, S_EMIT_WAIT
  } state_t;

  typedef struct packed {
    logic       clr_crc;    // start CRC at zero, address 0
    logic       crc_step;   // fold the byte read last cycle
    logic       rd_en;      // frame buffer read address select
    logic [1:0] rd_sel;     // 0 counter, 1 hi pos, 2 lo pos, 3 byte len-2
    logic       hdr_load;   // capture header byte
    logic [1:0] hdr_sel;    // 0 byte0, 1 byte2, 2 byte3
    logic       hi_load;
    logic       lo_load;
    logic       ent_load;   // capture decode entry
    logic       upd;        // compare/update value store
    logic       acct;
    logic       emit_load;  // load output register
    logic       clr_walk;
  } cmd_t;

  typedef struct packed {
    logic       crc_ok;
    logic       ent_stop;
    logic       ent_match;
    logic       pos_ok;
    logic       lo_in;      // hi position + 1 lies inside frame
    logic       changed;
  } sts_t;
endpackage
`default_nettype wire

[rtl/emsfd_ram.sv]
// ----------------------------------------------------------------------------
// emsfd_ram: generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module emsfd_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/emsfd_datapath.sv]
// ----------------------------------------------------------------------------
// emsfd_datapath: frame buffer, decode table, value store and accounting
// Executes controller commands; reports compare results as status.
// ----------------------------------------------------------------------------
`default_nettype none
module emsfd_datapath import emsfd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              cmd,
  output sts_t                   sts,
  // byte capture
  input  wire logic              byte_we,
  input  wire logic [FrameAw-1:0] byte_waddr,
  input  wire logic [7:0]        byte_wdata,
  input  wire logic [LenW-1:0]   len,
  input  wire logic [FrameAw-1:0] cnt_addr,
  // table write
  input  wire logic              tab_we,
  input  wire logic [EntAw-1:0]  tab_waddr,
  input  wire logic [30:0]       tab_wdata,
  input  wire logic [EntAw-1:0]  ent_idx,
  input  wire logic [31:0]       now_ms,
  input  wire logic [15:0]       watch_mask,
  // emit
  input  wire logic [EntAw-1:0]  emit_idx,
  input  wire logic              poll_we,
  output logic [7:0]             poll_latch,
  output logic [15:0]            emit_data,
  output logic [31:0]            burner_total,
  output logic [31:0]            hotwater_total
);
  logic [7:0] crc, byte_rd, b0, b2, b3, hi, lo;
  logic [30:0] ent;
  logic [30:0] tab_rd;
  logic [FrameAw-1:0] raddr;
  logic [8:0] pos;
  logic [15:0] vstore [NumEntries];
  logic [NumEntries-1:0] vvalid;
  logic [15:0] newv, oldv;
  logic [7:0] crc_sh;
  logic burner_w, hot_w;
  logic [31:0] burner_start, hotwater_start;
  logic [LenW-1:0] len_m2;

  assign len_m2 = len - LenW'(2);
  assign pos = {1'b0, ent[23:16]} - {1'b0, b3} + 9'd4;

  always_comb begin
    unique case (cmd.rd_sel)
      2'd0: raddr = cnt_addr;
      2'd1: raddr = pos[FrameAw-1:0];
      2'd2: raddr = FrameAw'(pos + 9'd1);
      default: raddr = len_m2[FrameAw-1:0];
    endcase
  end

  emsfd_ram #(.Width(8), .Depth(MaxFrame)) u_frame (
    .clk, .we(byte_we), .waddr(byte_waddr), .wdata(byte_wdata),
    .raddr(raddr), .rdata(byte_rd));

  emsfd_ram #(.Width(31), .Depth(NumEntries)) u_table (
    .clk, .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
    .raddr(ent_idx), .rdata(tab_rd));

  // xor 0x0C into the low bits, then rotate the top bit into bit 0
  assign crc_sh = crc[7] ? {crc[6:0] ^ 7'h0C, 1'b1} : {crc[6:0], 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.clr_crc) begin
      crc <= '0;
    end else if (cmd.crc_step) begin
      crc <= crc_sh ^ byte_rd;
    end
    if (cmd.hdr_load) begin
      unique case (cmd.hdr_sel)
        2'd0: b0 <= byte_rd;
        2'd1: b2 <= byte_rd;
        default: b3 <= byte_rd;
      endcase
    end
    if (cmd.ent_load) ent <= tab_rd;
    if (cmd.hi_load) hi <= byte_rd;
    if (cmd.lo_load) lo <= sts.lo_in ? byte_rd : 8'd0;
  end

  assign sts.crc_ok    = (crc == byte_rd);
  assign sts.ent_stop  = (ent[7:0] > b0) || (ent[15:8] > b2);
  assign sts.ent_match = (ent[7:0] == {4'd0, b0[3:0]}) && (ent[15:8] == b2) &&
                         (ent[23:16] >= b3);
  assign sts.pos_ok    = pos < {3'd0, len};
  assign sts.lo_in     = (pos + 9'd1) < {3'd0, len};

  always_comb begin
    unique case (ent[27:24])
      4'd0: newv = {15'd0, hi[ent[30:28]]};
      4'd1, 4'd2, 4'd4, 4'd6: newv = {8'd0, hi};
      4'd3, 4'd5: newv = {hi, lo};
      default: newv = '0;
    endcase
  end
  assign oldv = vvalid[ent_idx] ? vstore[ent_idx] : 16'd0;
  assign sts.changed = newv != oldv;
  assign emit_data = vvalid[emit_idx] ? vstore[emit_idx] : 16'd0;

  always_ff @(posedge clk) begin
    if (cmd.upd && sts.changed) vstore[ent_idx] <= newv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vvalid <= '0; poll_latch <= '0;
      burner_start <= '0; burner_total <= '0;
      hotwater_start <= '0; hotwater_total <= '0;
      burner_w <= 1'b0; hot_w <= 1'b0;
    end else begin
      if (poll_we) poll_latch <= byte_rd;
      if (cmd.clr_walk) begin
        burner_w <= 1'b0; hot_w <= 1'b0;
      end
      if (cmd.upd && sts.changed) begin
        vvalid[ent_idx] <= 1'b1;
        if (ent_idx == EntAw'(BurnerIdx) && watch_mask[BurnerIdx]) burner_w <= 1'b1;
        if (ent_idx == EntAw'(HotwaterIdx) && watch_mask[HotwaterIdx]) hot_w <= 1'b1;
      end
      if (cmd.acct) begin
        if (burner_w) begin
          if (vstore[BurnerIdx] != 16'd0) burner_start <= now_ms;
          else burner_total <= burner_total + (now_ms - burner_start);
        end
        if (hot_w) begin
          if (vstore[HotwaterIdx] != 16'd0) hotwater_start <= now_ms;
          else hotwater_total <= hotwater_total + (now_ms - hotwater_start);
        end
      end
    end
  end
endmodule
`default_nettype wire

[rtl/emsfd_ctrl.sv]
// ----------------------------------------------------------------------------
// emsfd_ctrl: frame controller
// Byte capture, CRC sweep, table walk and result sequencing.
// ----------------------------------------------------------------------------
`default_nettype none
module emsfd_ctrl import emsfd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               op,
  input  wire logic [7:0]         in_byte,
  input  wire logic               in_end,
  input  wire logic [4:0]         entry_count,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic [EntAw-1:0]        out_idx,
  output logic                    out_vvalid,
  output logic                    out_last,
  output cmd_t                    cmd,
  input  wire sts_t               sts,
  output logic                    byte_we,
  output logic [FrameAw-1:0]      byte_waddr,
  output logic [LenW-1:0]         len,
  output logic [FrameAw-1:0]      cnt_addr,
  output logic [EntAw-1:0]        ent_idx,
  output logic [EntAw-1:0]        emit_idx,
  output logic                    poll_we,
  output logic                    latch_now
);
  state_t state, state_next;
  logic [LenW-1:0] fill, fill_next, len_next;
  logic in_frame, in_frame_next;
  logic [LenW-1:0] cnt, cnt_next;
  logic [CntW-1:0] walk, walk_next, nwalk;
  logic [NumEntries-1:0] chg, chg_next;
  logic [CntW-1:0] nleft, nleft_next;
  logic accept, closing;
  logic [EntAw-1:0] first_chg;
  logic any_chg;
  logic [1:0] pend_status, pend_status_r;
  logic [EntAw-1:0] emit_sel_idx;
  logic emit_vv, emit_last;
  logic [1:0] st_next;

  assign accept  = in_valid && in_ready;
  assign nwalk   = (entry_count > 5'(NumEntries)) ? CntW'(NumEntries) : CntW'(entry_count);
  assign byte_waddr = fill[FrameAw-1:0];
  assign ent_idx = walk[EntAw-1:0];
  assign cnt_addr = cnt[FrameAw-1:0];
  assign emit_idx = first_chg;

  always_comb begin
    first_chg = '0;
    any_chg = 1'b0;
    for (int i = NumEntries - 1; i >= 0; i--) begin
      if (chg[i]) begin
        first_chg = EntAw'(i);
        any_chg = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; fill <= '0; in_frame <= 1'b0; len <= '0; cnt <= '0;
      walk <= '0; chg <= '0; nleft <= '0;
      out_valid <= 1'b0; out_status <= '0; out_idx <= '0; out_vvalid <= 1'b0;
      out_last <= 1'b0;
    end else begin
      state <= state_next; fill <= fill_next; in_frame <= in_frame_next;
      len <= len_next; cnt <= cnt_next; walk <= walk_next; chg <= chg_next;
      nleft <= nleft_next;
      if (cmd.emit_load) begin
        out_valid <= 1'b1;
        out_status <= pend_status;
        out_idx <= emit_sel_idx;
        out_vvalid <= emit_vv;
        out_last <= emit_last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) pend_status_r <= '0;
    else pend_status_r <= st_next;
  end
  assign pend_status = pend_status_r;

  always_comb begin
    state_next = state; fill_next = fill; in_frame_next = in_frame;
    len_next = len; cnt_next = cnt; walk_next = walk; chg_next = chg;
    nleft_next = nleft;
    st_next = pend_status_r;
    cmd = '0; in_ready = 1'b0; byte_we = 1'b0; poll_we = 1'b0;
    latch_now = 1'b0;
    emit_sel_idx = first_chg; emit_vv = any_chg;
    emit_last = !any_chg || nleft == CntW'(1) ||
                ($countones(chg) == 1);
    closing = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = !out_valid;
        cnt_next = '0;
        cmd.rd_sel = 2'd0;
        if (accept && op == OpByte && (in_frame || in_byte != 8'd0)) begin
          latch_now = 1'b1;
          if (fill < LenW'(MaxFrame)) begin
            byte_we = 1'b1;
            fill_next = fill + LenW'(1);
          end
          in_frame_next = 1'b1;
          closing = in_end || (fill_next >= LenW'(MaxFrame));
          if (closing) begin
            len_next = fill_next; fill_next = '0; in_frame_next = 1'b0;
            cmd.clr_crc = 1'b1;
            cnt_next = LenW'(1);
            state_next = S_CRC;
          end
        end
      end
      S_CRC: begin
        // byte read at address cnt-1 is on the read bus now
        if (len == LenW'(2)) begin
          poll_we = 1'b1; st_next = StPoll; chg_next = '0;
          state_next = S_EMIT_RD;
        end else if (len <= LenW'(4)) begin
          st_next = StShort; chg_next = '0; state_next = S_EMIT_RD;
        end else begin
          cmd.crc_step = 1'b1;
          if (cnt == LenW'(1)) begin cmd.hdr_load = 1'b1; cmd.hdr_sel = 2'd0; end
          if (cnt == LenW'(3)) begin cmd.hdr_load = 1'b1; cmd.hdr_sel = 2'd1; end
          if (cnt == LenW'(4)) begin cmd.hdr_load = 1'b1; cmd.hdr_sel = 2'd2; end
          if (cnt == len - LenW'(2)) begin
            cmd.rd_sel = 2'd3; state_next = S_CRC_CHK;
          end else begin
            cmd.rd_sel = 2'd0; cnt_next = cnt + LenW'(1);
          end
        end
      end
      S_CRC_CHK: begin
        chg_next = '0;
        walk_next = '0;
        cmd.clr_walk = 1'b1;
        // 5-byte frame: the sweep stops before byte 3, which is byte len-2 here
        if (len == LenW'(5)) begin cmd.hdr_load = 1'b1; cmd.hdr_sel = 2'd2; end
        if (!sts.crc_ok) begin
          st_next = StCrc; state_next = S_EMIT_RD;
        end else begin
          st_next = StOk;
          state_next = (nwalk == '0) ? S_ACCT : S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        cmd.ent_load = 1'b0;
        state_next = S_WALK_B0;
      end
      S_WALK_B0: begin
        cmd.ent_load = 1'b1;
        state_next = S_WALK_HI;
      end
      S_WALK_HI: begin
        cmd.rd_sel = 2'd1;
        if (sts.ent_stop) state_next = S_ACCT;
        else if (!sts.ent_match || !sts.pos_ok) begin
          walk_next = walk + CntW'(1);
          state_next = (walk + CntW'(1) >= nwalk) ? S_ACCT : S_WALK_RD;
        end else state_next = S_WALK_LO;
      end
      S_WALK_LO: begin
        cmd.hi_load = 1'b1; cmd.rd_sel = 2'd2;
        state_next = S_WALK_UPD;
      end
      S_WALK_UPD: begin
        cmd.lo_load = 1'b1;
        state_next = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        cmd.upd = 1'b1;
        if (sts.changed) chg_next[ent_idx] = 1'b1;
        walk_next = walk + CntW'(1);
        state_next = (walk + CntW'(1) >= nwalk) ? S_ACCT : S_WALK_RD;
      end
      S_ACCT: begin
        cmd.acct = 1'b1;
        nleft_next = CntW'(NumEntries);
        state_next = S_EMIT_RD;
      end
      S_EMIT_RD: begin
        if (!out_valid || out_ready) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.emit_load = 1'b1;
          if (any_chg) chg_next[first_chg] = 1'b0;
          nleft_next = nleft - CntW'(1);
          state_next = emit_last ? S_IDLE : S_EMIT;
          if (st_next != StOk) emit_last = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (st_next != StOk) begin emit_vv = 1'b0; emit_sel_idx = '0; end
    if (!(st_next == StOk) ) emit_last = 1'b1;
  end
endmodule
`default_nettype wire

[rtl/ems_frame_register_decoder_core.sv]
// ----------------------------------------------------------------------------
// ems_frame_register_decoder_core: EMS bus frame decoder, top level
// Frame buffering, CRC check, decode table walk and on-time accounting.
// ----------------------------------------------------------------------------
// Channel      Dir  Contents
// s_axis       in   bus bytes and decode table writes
// m_axis       out  frame status and changed values
// apb          in   watch_mask (0x0), entry_count (0x4)
//
// A closing byte starts a CRC sweep (skipped for frames of up to 4 bytes),
// then, if the CRC is good, a table walk over the decode entries, then the
// results go out while m_tready is high. Input is stalled while a frame
// is processed or a result waits.
// Reset is synchronous; stored values read as zero until first changed.
// ----------------------------------------------------------------------------
`default_nettype none
module ems_frame_register_decoder_core import emsfd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // tdata: operation, bus_byte, frame_end, now_ms, entry_index, entry_sender,
  //        entry_message, entry_offset, entry_type (pad to 80 bits)
  input  wire logic [79:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // tdata: frame_status, poll_address, value_index, value_data, value_valid,
  //        burner_on_ms, hotwater_on_ms (pad to 96 bits)
  output logic [95:0]      m_tdata,
  output logic             m_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  cmd_t cmd;
  sts_t sts;
  logic [15:0] watch_mask;
  logic [4:0] entry_count;
  logic byte_we, poll_we, latch_now;
  logic [FrameAw-1:0] byte_waddr, cnt_addr;
  logic [LenW-1:0] len;
  logic [EntAw-1:0] ent_idx, emit_idx, out_idx;
  logic [1:0] out_status;
  logic out_vvalid, tab_we;
  logic [7:0] poll_latch;
  logic [15:0] emit_data, out_data;
  logic [31:0] btot, htot, now_r;
  logic cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  always_ff @(posedge clk) begin
    if (rst) begin
      watch_mask <= 16'd20; entry_count <= 5'd16;
    end else if (cfg_we && paddr[1:0] == 2'd0) begin
      if (paddr[2] == RegWatch) watch_mask <= pwdata[15:0];
      else entry_count <= pwdata[4:0];
    end
  end
  assign prdata = (paddr[2] == RegWatch) ? {16'd0, watch_mask} : {27'd0, entry_count};

  always_ff @(posedge clk) begin
    if (latch_now) now_r <= s_tdata[41:10];
    if (cmd.emit_load) out_data <= emit_data;
  end

  assign tab_we = s_tvalid && s_tready && s_tdata[0] == OpTable;

  emsfd_ctrl u_ctrl (
    .clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready), .op(s_tdata[0]),
    .in_byte(s_tdata[8:1]), .in_end(s_tdata[9]), .entry_count,
    .out_ready(m_tready), .out_valid(m_tvalid), .out_status, .out_idx,
    .out_vvalid, .out_last(m_tlast), .cmd, .sts, .byte_we, .byte_waddr, .len,
    .cnt_addr, .ent_idx, .emit_idx, .poll_we, .latch_now);

  emsfd_datapath u_dp (
    .clk, .rst, .cmd, .sts, .byte_we, .byte_waddr, .byte_wdata(s_tdata[8:1]),
    .len, .cnt_addr, .tab_we, .tab_waddr(s_tdata[45:42]),
    .tab_wdata(s_tdata[76:46]), .ent_idx, .now_ms(now_r), .watch_mask,
    .emit_idx, .poll_we, .poll_latch, .emit_data, .burner_total(btot),
    .hotwater_total(htot));

  assign m_tdata = {1'b0, htot, btot, out_vvalid,
                    out_vvalid ? out_data : 16'd0, out_idx, poll_latch, out_status};
endmodule
`default_nettype wire

[verif/ems_frame_checker.sv]
// ----------------------------------------------------------------------------
// ems_frame_checker: prediction and comparison for the EMS frame decoder
// Watches the byte/table input stream, the register port and the result
// stream, keeps its own copy of the decoder state, and compares every
// result transaction field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module ems_frame_checker import emsfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [79:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [95:0] m_tdata,
  input  logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fails,
  output int          pending,
  output int          results_seen
);
  typedef struct packed {
    logic [6:0] typ;
    logic [7:0] off;
    logic [7:0] msg;
    logic [7:0] snd;
  } dec_entry_t;

  typedef struct {
    logic [1:0]  status;
    logic [7:0]  poll;
    logic [3:0]  idx;
    logic [15:0] data;
    logic        vld;
    logic [31:0] burner;
    logic [31:0] hotwater;
    logic        lst;
  } frame_result_t;

  frame_result_t result_q[$];

  logic [15:0] watch;
  logic [4:0]  ent_cnt;
  logic [7:0]  fbuf[MaxFrame];
  int          flen;
  logic        in_frm;
  dec_entry_t  dtab[NumEntries];
  logic [15:0] vstore[NumEntries];
  logic [7:0]  poll_q;
  logic [31:0] burn_start, burn_total, hw_start, hw_total;

  function automatic logic [7:0] frame_crc(int n);
    logic [7:0] c;
    logic       cy;
    c = 8'h00;
    for (int k = 0; k < n; k++) begin
      cy = c[7];
      if (cy) c = c ^ 8'd12;
      c = {c[6:0], cy} ^ fbuf[k];
    end
    return c;
  endfunction

  function automatic logic [15:0] extract_value(int pos, int len, logic [6:0] typ);
    logic [7:0] hi, lo;
    hi = fbuf[pos];
    lo = (pos + 1 < len) ? fbuf[pos + 1] : 8'h00;
    case (typ[3:0])
      4'd0: return {15'd0, hi[typ[6:4]]};
      4'd1, 4'd2, 4'd4, 4'd6: return {8'h00, hi};
      4'd3, 4'd5: return {hi, lo};
      default: return 16'h0000;
    endcase
  endfunction

  function automatic void push_result(logic [1:0] st, logic [3:0] idx,
                                      logic [15:0] d, logic v, logic l);
    frame_result_t r;
    r.status = st; r.poll = poll_q; r.idx = idx; r.data = d; r.vld = v;
    r.burner = burn_total; r.hotwater = hw_total; r.lst = l;
    result_q.push_back(r);
  endfunction

  // one accepted input transaction
  function automatic void decode_step(logic [79:0] d);
    logic [7:0]  b;
    logic [31:0] now;
    int          len, n, pos, nchg;
    int          chg[NumEntries];
    logic [15:0] watched, v;
    dec_entry_t  e;
    b = d[8:1];
    now = d[41:10];
    nchg = 0;
    watched = '0;
    if (d[0] == OpTable) begin
      dtab[d[45:42]] = d[76:46];
      return;
    end
    if (!in_frm && b == 8'h00) return;
    if (flen < MaxFrame) begin
      fbuf[flen] = b;
      flen++;
    end
    in_frm = 1'b1;
    if (!d[9] && flen < MaxFrame) return;
    len = flen;
    flen = 0;
    in_frm = 1'b0;
    if (len == 2) begin
      poll_q = fbuf[0];
      push_result(StPoll, 4'd0, 16'd0, 1'b0, 1'b1);
      return;
    end
    if (len <= 4) begin
      push_result(StShort, 4'd0, 16'd0, 1'b0, 1'b1);
      return;
    end
    if (frame_crc(len - 2) != fbuf[len - 2]) begin
      push_result(StCrc, 4'd0, 16'd0, 1'b0, 1'b1);
      return;
    end
    n = (ent_cnt < NumEntries) ? ent_cnt : NumEntries;
    for (int i = 0; i < n; i++) begin
      e = dtab[i];
      if (!(e.snd <= fbuf[0] && e.msg <= fbuf[2])) break;
      if (e.snd != {4'h0, fbuf[0][3:0]} || e.msg != fbuf[2] || e.off < fbuf[3]) continue;
      pos = int'(e.off) - int'(fbuf[3]) + 4;
      if (pos >= len) continue;
      v = extract_value(pos, len, e.typ);
      if (v != vstore[i]) begin
        vstore[i] = v;
        chg[nchg] = i;
        nchg++;
        if (watch[i]) watched[i] = 1'b1;
      end
    end
    if (watched[BurnerIdx]) begin
      if (vstore[BurnerIdx] != 0) burn_start = now;
      else burn_total = burn_total + (now - burn_start);
    end
    if (watched[HotwaterIdx]) begin
      if (vstore[HotwaterIdx] != 0) hw_start = now;
      else hw_total = hw_total + (now - hw_start);
    end
    if (nchg == 0) begin
      push_result(StOk, 4'd0, 16'd0, 1'b0, 1'b1);
      return;
    end
    for (int k = 0; k < nchg; k++)
      push_result(StOk, 4'(chg[k]), vstore[chg[k]], 1'b1, k == nchg - 1);
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      fails++;
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    frame_result_t r;
    if (rst) begin
      watch = 16'd20;
      ent_cnt = 5'd16;
      flen = 0;
      in_frm = 1'b0;
      for (int i = 0; i < NumEntries; i++) vstore[i] = '0;
      poll_q = '0;
      burn_start = '0; burn_total = '0; hw_start = '0; hw_total = '0;
      result_q.delete();
      fails = 0;
      results_seen = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          RegWatch: watch = pwdata[15:0];
          RegCount: ent_cnt = pwdata[4:0];
        endcase
      end
      if (s_tvalid && s_tready) decode_step(s_tdata);
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (result_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result transaction 0x%0h", $time, m_tdata);
        end else begin
          r = result_q.pop_front();
          check_field("frame_status", r.status, m_tdata[1:0]);
          check_field("poll_address", r.poll, m_tdata[9:2]);
          check_field("value_index", r.idx, m_tdata[13:10]);
          check_field("value_data", r.data, m_tdata[29:14]);
          check_field("value_valid", r.vld, m_tdata[30]);
          check_field("burner_on_ms", r.burner, m_tdata[62:31]);
          check_field("hotwater_on_ms", r.hotwater, m_tdata[94:63]);
          check_field("last", r.lst, m_tlast);
        end
      end
    end
    pending = result_q.size();
  end
endmodule

[verif/tb_ems_frame_register_decoder_core.sv]
// ----------------------------------------------------------------------------
// tb_ems_frame_register_decoder_core: testbench top for the EMS frame decoder
// Loads a sorted decode table, sends directed corner frames and then random
// frames (good CRC, bad CRC, short, poll, full buffer, noise) under random
// flow control and register settings; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_ems_frame_register_decoder_core import emsfd_pkg::*;;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // tdata: operation, bus_byte, frame_end, now_ms, entry_index, entry_sender,
  //        entry_message, entry_offset, entry_type (pad to 80 bits)
  logic [79:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // tdata: frame_status, poll_address, value_index, value_data, value_valid,
  //        burner_on_ms, hotwater_on_ms (pad to 96 bits)
  logic [95:0] m_tdata;
  logic        m_tlast;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fails, pending, results_seen;

  int          items = 0, frames = 0, cfg_writes = 0, idle_cycles = 0;
  logic        hold_req = 1'b0, no_gaps = 1'b0;
  logic [31:0] ms = 32'd100;
  logic [7:0]  fb[MaxFrame];

  ems_frame_register_decoder_core dut (.*);

  ems_frame_checker chk (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog: cycles without any transaction on either stream
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("timeout at %0t, %0d results outstanding", $time, pending);
      $display("** ems_frame_register_decoder_core: FAILED **");
      $finish;
    end
  end

  // receiver side
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else if (no_gaps) begin
        m_tready <= 1'b1;
      end else if ($urandom_range(0, 99) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  function automatic int pick_gap();
    if (no_gaps || $urandom_range(0, 9) < 7) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(logic [79:0] d);
    int g;
    g = pick_gap();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    items++;
  endtask

  task automatic send_byte(logic [7:0] b, logic fe);
    logic [79:0] d;
    d = 80'({$urandom(), $urandom(), $urandom()});
    d[79:77] = '0;
    ms = ($urandom_range(0, 49) == 0) ? $urandom() : ms + $urandom_range(1, 5000);
    d[0] = OpByte;
    d[8:1] = b;
    d[9] = fe;
    d[41:10] = ms;
    send_item(d);
  endtask

  task automatic write_entry(logic [3:0] idx, logic [7:0] snd, logic [7:0] msg,
                             logic [7:0] off, logic [6:0] typ);
    logic [79:0] d;
    d = 80'({$urandom(), $urandom(), $urandom()});
    d[79:77] = '0;
    d[0] = OpTable;
    d[45:42] = idx;
    d[76:46] = {typ, off, msg, snd};
    send_item(d);
  endtask

  // sender 8, messages rising every four entries, mixed value kinds
  task automatic load_table();
    logic [3:0] kinds[8] = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd9};
    for (int i = 0; i < NumEntries; i++)
      write_entry(4'(i), 8'h08, 8'h20 + 8'(i / 4), 8'((i % 4) * 2),
                  {3'($urandom_range(0, 7)), kinds[i % 8]});
  endtask

  function automatic logic [7:0] crc_of(int n);
    logic [7:0] c;
    logic       cy;
    c = 8'h00;
    for (int k = 0; k < n; k++) begin
      cy = c[7];
      if (cy) c = c ^ 8'd12;
      c = {c[6:0], cy} ^ fb[k];
    end
    return c;
  endfunction

  // len bytes; good selects a matching CRC byte; closed by the end mark
  // unless endmark is clear (then only a full buffer closes it)
  task automatic send_frame(int len, bit good, bit endmark);
    for (int k = 0; k < len; k++)
      fb[k] = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom());
    case ($urandom_range(0, 5))
      0: fb[0] = 8'h88;
      1: fb[0] = 8'($urandom_range(1, 255));
      default: fb[0] = 8'h08;
    endcase
    if (len > 2) fb[2] = 8'h20 + 8'($urandom_range(0, 3));
    if (len > 3) fb[3] = 8'($urandom_range(0, 3));
    if (len >= 5) fb[len - 2] = good ? crc_of(len - 2) : crc_of(len - 2) ^ 8'h5a;
    for (int k = 0; k < len; k++) send_byte(fb[k], endmark && k == len - 1);
    frames++;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic reg_write(logic reg_sel, logic [31:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    cfg_writes++;
  endtask

  initial begin
    int r;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    load_table();
    send_byte(8'h00, 1'b1);        // zero outside a frame, skipped
    send_byte(8'h00, 1'b0);
    send_frame(2, 1'b0, 1'b1);     // poll
    send_frame(1, 1'b0, 1'b1);
    send_frame(3, 1'b0, 1'b1);
    send_frame(4, 1'b0, 1'b1);
    send_frame(6, 1'b0, 1'b1);     // CRC failure
    send_frame(5, 1'b1, 1'b1);     // 16-bit value may run past the end
    send_frame(9, 1'b1, 1'b1);
    send_frame(MaxFrame, 1'b1, 1'b0); // closes on a full buffer
    settle();
    reg_write(RegWatch, 32'hffff);
    reg_write(RegCount, 32'd31);   // saturates
    send_frame(8, 1'b1, 1'b1);
    send_frame(7, 1'b1, 1'b1);
    settle();
    reg_write(RegWatch, 32'h0000);
    reg_write(RegCount, 32'd0);
    send_frame(8, 1'b1, 1'b1);
    settle();
    reg_write(RegWatch, 32'h0014);
    reg_write(RegCount, 32'd16);

    hold_req = 1'b1;               // long receiver stall while bytes keep coming
    no_gaps = 1'b1;
    for (int k = 0; k < 4; k++) send_frame(5, 1'b1, 1'b1);
    no_gaps = 1'b0;

    // random part
    while (items < 260) begin
      if (frames > 0 && frames % 20 == 0) begin
        settle();               // sender waits for every result
        reg_write(RegWatch, ($urandom_range(0, 3) == 0) ? 32'hffff : $urandom());
        reg_write(RegCount, ($urandom_range(0, 2) == 0) ? 32'd16 : $urandom_range(0, 31));
      end
      r = $urandom_range(0, 99);
      if (r < 4) write_entry(4'($urandom()), 8'($urandom()), 8'($urandom()),
                             8'($urandom()), 7'($urandom()));
      else if (r < 7) load_table();
      else if (r < 11) send_byte(8'($urandom()), 1'($urandom()));
      else if (r < 17) send_frame($urandom_range(1, 4), 1'b0, 1'b1);
      else if (r < 23) send_frame($urandom_range(5, 12), 1'b0, 1'b1);
      else if (r < 26) send_frame(MaxFrame, 1'b1, 1'($urandom_range(0, 1)));
      else if (r < 30) send_frame($urandom_range(13, MaxFrame), 1'b1, 1'b1);
      else send_frame($urandom_range(5, 12), 1'b1, 1'b1);
    end

    settle();
    repeat (100) @(posedge clk);
    $display("Covered %0d input transactions in %0d frames, %0d register writes,",
             items, frames, cfg_writes);
    $display("and checked %0d result transactions.", results_seen);
    if (fails == 0) $display("** ems_frame_register_decoder_core: PASSED **");
    else $display("** ems_frame_register_decoder_core: FAILED **");
    $finish;
  end
endmodule

[files.f]
rtl/emsfd_pkg.sv
rtl/emsfd_ram.sv
rtl/emsfd_datapath.sv
rtl/emsfd_ctrl.sv
rtl/ems_frame_register_decoder_core.sv
verif/ems_frame_checker.sv
verif/tb_ems_frame_register_decoder_core.sv
